FILE: rtl/arfm_pkg.sv
// shared constants and types for the auto-ranging reciprocal frequency meter
// no dependencies; used by the top level and the checker
package arfm_pkg;

	localparam int FREQ_W = 27;
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	localparam logic [FREQ_W-1:0] SLOW_CLOCK_RST = 27'd1000000;
	localparam logic [FREQ_W-1:0] FAST_CLOCK_RST = 27'd72000000;
	localparam logic [FREQ_W-1:0] UP_THRESH_RST  = 27'd2000;
	localparam logic [FREQ_W-1:0] DOWN_THRESH_RST = 27'd1500;

	typedef enum logic [1:0] {
		REG_SLOW_CLOCK  = 2'd0,
		REG_FAST_CLOCK  = 2'd1,
		REG_UP_THRESH   = 2'd2,
		REG_DOWN_THRESH = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic in_ready;
		logic finish_fire;
	} ctrl_t;

endpackage

FILE: rtl/autorange_reciprocal_freq_meter.sv
// top level: configuration registers, range control sequencer, output register
// depends on arfm_pkg and arfm_divider
//
// One capture count is taken per transaction. A nonzero count goes through a
// shared restoring divider that produces one quotient bit per cycle, for
// DW = max(27, COUNT_WIDTH) + 1 quotient bits. Its result is loaded into the
// output register from the finish state once the divider reports done, and
// the next count can be taken when the sequencer is back in idle. A count of
// zero skips the divider and goes straight to the finish state. A result that
// finds the output register still full waits there until the register is
// read. in_ready stays low while an item is in the divider or waiting for the
// output register; the output register lets a new count be taken while the
// previous result is unread.
// Slow range rounds to nearest (half up) by adding half the count to the
// slow clock before the divide; fast range truncates. A range switch reports
// the held frequency with range_changed set. Registers are written over APB
// at byte addresses 0, 4, 8 and 12 and should only change while the block
// is idle.
module autorange_reciprocal_freq_meter #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [COUNT_WIDTH-1:0]       capture_count,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [arfm_pkg::FREQ_W-1:0]  frequency,
	output logic                         range_fast,
	output logic                         range_changed,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [arfm_pkg::ADDR_W-1:0]  paddr,
	input  logic [arfm_pkg::DATA_W-1:0]  pwdata,
	output logic [arfm_pkg::DATA_W-1:0]  prdata,
	output logic                         pready
);

	localparam int FW = arfm_pkg::FREQ_W;
	localparam int DW = ((COUNT_WIDTH > FW) ? COUNT_WIDTH : FW) + 1;

	logic [FW-1:0] slow_clock_q;
	logic [FW-1:0] fast_clock_q;
	logic [FW-1:0] up_thresh_q;
	logic [FW-1:0] down_thresh_q;

	arfm_pkg::state_t state_q, state_d;
	arfm_pkg::ctrl_t  ctrl;
	arfm_pkg::reg_idx_t reg_idx;

	logic          fast_range_q;
	logic [FW-1:0] held_freq_q;
	logic          zero_q;
	logic          out_valid_q;
	logic [FW-1:0] freq_q;
	logic          range_fast_q;
	logic          changed_q;

	logic          in_fire;
	logic          count_zero;
	logic          div_start;
	logic          div_done;
	logic [DW-1:0] dividend;
	logic [DW-1:0] quotient;
	logic [FW-1:0] q_freq;
	logic          out_free;
	logic          wr_en;

	// configuration port
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = arfm_pkg::reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slow_clock_q  <= arfm_pkg::SLOW_CLOCK_RST;
			fast_clock_q  <= arfm_pkg::FAST_CLOCK_RST;
			up_thresh_q   <= arfm_pkg::UP_THRESH_RST;
			down_thresh_q <= arfm_pkg::DOWN_THRESH_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				arfm_pkg::REG_SLOW_CLOCK:  slow_clock_q  <= pwdata[FW-1:0];
				arfm_pkg::REG_FAST_CLOCK:  fast_clock_q  <= pwdata[FW-1:0];
				arfm_pkg::REG_UP_THRESH:   up_thresh_q   <= pwdata[FW-1:0];
				arfm_pkg::REG_DOWN_THRESH: down_thresh_q <= pwdata[FW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			arfm_pkg::REG_SLOW_CLOCK:  prdata = {{(arfm_pkg::DATA_W-FW){1'b0}}, slow_clock_q};
			arfm_pkg::REG_FAST_CLOCK:  prdata = {{(arfm_pkg::DATA_W-FW){1'b0}}, fast_clock_q};
			arfm_pkg::REG_UP_THRESH:   prdata = {{(arfm_pkg::DATA_W-FW){1'b0}}, up_thresh_q};
			arfm_pkg::REG_DOWN_THRESH: prdata = {{(arfm_pkg::DATA_W-FW){1'b0}}, down_thresh_q};
			default:                   prdata = '0;
		endcase
	end

	// divider feed, started straight from the accepted transaction
	assign in_fire    = in_valid && ctrl.in_ready;
	assign count_zero = (capture_count == '0);
	assign div_start  = in_fire && !count_zero;

	always_comb begin
		if (fast_range_q) begin
			dividend = DW'(fast_clock_q);
		end else begin
			dividend = DW'(slow_clock_q) + DW'(capture_count[COUNT_WIDTH-1:1]);
		end
	end

	arfm_divider #(
		.DIVIDEND_W (DW),
		.DIVISOR_W  (COUNT_WIDTH)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (capture_count),
		.done     (div_done),
		.quotient (quotient)
	);

	assign q_freq   = quotient[FW-1:0];
	assign out_free = !out_valid_q || out_ready;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= arfm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			arfm_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = count_zero ? arfm_pkg::ST_FINISH : arfm_pkg::ST_CALC;
				end
			end
			arfm_pkg::ST_CALC: begin
				if (div_done) begin
					state_d = arfm_pkg::ST_FINISH;
				end
			end
			arfm_pkg::ST_FINISH: begin
				if (out_free) begin
					state_d = arfm_pkg::ST_IDLE;
				end
			end
			default: state_d = arfm_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl = '0;
		unique case (state_q)
			arfm_pkg::ST_IDLE:   ctrl.in_ready = 1'b1;
			arfm_pkg::ST_CALC:   ;
			arfm_pkg::ST_FINISH: ctrl.finish_fire = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			zero_q <= count_zero;
		end
	end

	// range decision and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fast_range_q <= 1'b0;
			held_freq_q  <= '0;
			out_valid_q  <= 1'b0;
			freq_q       <= '0;
			range_fast_q <= 1'b0;
			changed_q    <= 1'b0;
		end else begin
			if (ctrl.finish_fire) begin
				out_valid_q <= 1'b1;
				if (zero_q) begin
					freq_q       <= held_freq_q;
					range_fast_q <= fast_range_q;
					changed_q    <= 1'b0;
				end else if (!fast_range_q) begin
					if (q_freq > up_thresh_q) begin
						fast_range_q <= 1'b1;
						freq_q       <= held_freq_q;
						range_fast_q <= 1'b1;
						changed_q    <= 1'b1;
					end else begin
						held_freq_q  <= q_freq;
						freq_q       <= q_freq;
						range_fast_q <= 1'b0;
						changed_q    <= 1'b0;
					end
				end else begin
					if (q_freq < down_thresh_q) begin
						fast_range_q <= 1'b0;
						freq_q       <= held_freq_q;
						range_fast_q <= 1'b0;
						changed_q    <= 1'b1;
					end else begin
						held_freq_q  <= q_freq;
						freq_q       <= q_freq;
						range_fast_q <= 1'b1;
						changed_q    <= 1'b0;
					end
				end
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready      = ctrl.in_ready;
	assign out_valid     = out_valid_q;
	assign frequency     = freq_q;
	assign range_fast    = range_fast_q;
	assign range_changed = changed_q;

endmodule

FILE: rtl/arfm_divider.sv
// radix-2 restoring divider, one quotient bit per cycle
// depends on nothing but its parameters; used by the top level
module arfm_divider #(
	parameter int DIVIDEND_W = 28,
	parameter int DIVISOR_W  = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic                  done,
	output logic [DIVIDEND_W-1:0] quotient
);

	localparam int STEP_W = $clog2(DIVIDEND_W + 1);

	logic [DIVIDEND_W-1:0] acc_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  divisor_q;
	logic [STEP_W-1:0]     step_q;
	logic                  busy_q;
	logic                  done_q;

	logic [DIVISOR_W:0]   shifted;
	logic [DIVISOR_W+1:0] diff;
	logic                 borrow;

	// bring down the next dividend bit and try a subtract
	assign shifted = {rem_q, acc_q[DIVIDEND_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, divisor_q};
	assign borrow  = diff[DIVISOR_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(DIVIDEND_W);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q     <= dividend;
			rem_q     <= '0;
			divisor_q <= divisor;
		end else if (busy_q) begin
			acc_q <= {acc_q[DIVIDEND_W-2:0], ~borrow};
			rem_q <= borrow ? shifted[DIVISOR_W-1:0] : diff[DIVISOR_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = acc_q;

endmodule

FILE: rtl/arfm_checker.sv
// port-level checks for the frequency meter, bound to the top level
// depends on arfm_pkg and autorange_reciprocal_freq_meter
module arfm_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [arfm_pkg::FREQ_W-1:0] frequency,
	input logic                        range_fast,
	input logic                        range_changed,
	input logic                        psel,
	input logic                        penable,
	input logic                        pwrite,
	input logic [arfm_pkg::ADDR_W-1:0] paddr,
	input logic [arfm_pkg::DATA_W-1:0] pwdata,
	input logic [arfm_pkg::DATA_W-1:0] prdata,
	input logic                        pready
);

	// one transaction at a time through the sequencer
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken again right after a transaction");

	// a stalled result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(frequency)
			&& $stable(range_fast) && $stable(range_changed)))
		else $error("result changed while stalled");

	// a register reads back what was just written to it
	a_reg_readback: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && pready)
		##1 (psel && !pwrite && paddr == $past(paddr))
		|-> prdata == {{(arfm_pkg::DATA_W-arfm_pkg::FREQ_W){1'b0}},
			$past(pwdata[arfm_pkg::FREQ_W-1:0])})
		else $error("register readback mismatch");

endmodule

bind autorange_reciprocal_freq_meter arfm_checker u_arfm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.frequency     (frequency),
	.range_fast    (range_fast),
	.range_changed (range_changed),
	.psel          (psel),
	.penable       (penable),
	.pwrite        (pwrite),
	.paddr         (paddr),
	.pwdata        (pwdata),
	.prdata        (prdata),
	.pready        (pready)
);
